>>> sv/pss_pkg.sv
// Package for the point stream subdivider: word types, controller states,
// command/status structs and shared constants.
// No dependencies.
package pss_pkg;

    // Field and port widths
    localparam int COORD_W = 16;
    localparam int LIMIT_W = 16;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Default bound on words emitted per input point
    localparam int MAX_EMIT_DEF = 64;

    // Register map (word index taken from paddr[ADDR_W-1:2])
    localparam logic [ADDR_W-3:0] REG_STEP_LIMIT = '0;
    localparam logic [LIMIT_W-1:0] STEP_LIMIT_RST = 16'd1152;

    // Serial divider: 33-bit magnitude dividend, 16-bit divisor, 17 quotient bits
    localparam int DIV_N_W = 33;
    localparam int DIV_D_W = 16;
    localparam int DIV_Q_W = 17;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic                      beam_on;
        logic                      frame_start;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      out_beam;
        logic                      last;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CEIL_GO,
        ST_CEIL_RUN,
        ST_MUL,
        ST_DIVX_GO,
        ST_DIVX_RUN,
        ST_DIVY_GO,
        ST_DIVY_RUN,
        ST_EMIT_MID,
        ST_EMIT_LAST
    } t_state;

    typedef enum logic [1:0] {
        DIV_CEIL,
        DIV_X,
        DIV_Y
    } t_div_sel;

    // Controller -> datapath
    typedef struct packed {
        logic     load;
        logic     cap_mx;
        logic     div_start;
        t_div_sel div_sel;
        logic     cap_k;
        logic     mul;
        logic     cap_qx;
        logic     cap_qy;
        logic     emit_mid;
        logic     emit_last;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic pass;
        logic far;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

>>> sv/point_stream_subdivider.sv
// Top level of the point stream subdivider: APB register, controller and datapath.
// Depends on pss_pkg, pss_ctrl, pss_dp (and pss_div below it).
//
// Usage: input words (x, y, beam, frame start) arrive on the in channel
// (i_in_valid / o_in_stall); output words (x, y, beam, last) leave on the
// out channel (o_out_valid / i_out_stall). Each input yields zero or more
// intermediate words followed by the target itself with last set.
// A target that is close enough, opens a frame or has no previous point goes from
// the check state straight to the emit of the target word; the block then returns
// to idle for the next input.
// Each intermediate word takes three passes through one shared serial divider
// (start, one step per quotient bit, done; step count, then x, then y) plus check,
// multiply and emit steps. The block works on one input at a time; it takes the
// next input as soon as the target word is loaded into the output register,
// even if that word is stalled.
// A stalled output word holds; the sequencer waits for the register to free.
// Reset clears the previous point (the first input then passes through), sets
// step_limit to 1152 and empties the output register. step_limit is written over APB
// at address 0; the user must do so only while the block is idle (not enforced).
module point_stream_subdivider #(
    parameter int MAX_EMIT = pss_pkg::MAX_EMIT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input points
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pss_pkg::t_in_word              i_in_word,
    // Output points
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pss_pkg::t_out_word             o_out_word,
    // Register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pss_pkg::ADDR_W-1:0]     paddr,
    input  logic [pss_pkg::DATA_W-1:0]     pwdata,
    output logic [pss_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    logic [pss_pkg::LIMIT_W-1:0] r_step_limit;
    logic                        reg_hit;
    pss_pkg::t_cmd               cmd;
    pss_pkg::t_status            status;

    // Step limit register
    assign reg_hit = (paddr[pss_pkg::ADDR_W-1:2] == pss_pkg::REG_STEP_LIMIT);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= pss_pkg::STEP_LIMIT_RST;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_step_limit <= pwdata[pss_pkg::LIMIT_W-1:0];
        end
    end

    assign prdata = reg_hit ? {{(pss_pkg::DATA_W-pss_pkg::LIMIT_W){1'b0}}, r_step_limit}
                            : '0;

    pss_ctrl #(
        .MAX_EMIT (MAX_EMIT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pss_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_word    (i_in_word),
        .i_step_limit (r_step_limit),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_word   (o_out_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall)
    );

    // An accepted point keeps the input stalled for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a point");

    // A pending output word is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_mid || cmd.emit_last) |-> (!o_out_valid || !i_out_stall))
        else $error("output word overwritten while stalled");

    // After an intermediate word leaves, its target is still in work
    a_mid_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_word.last) |-> o_in_stall)
        else $error("input taken while a target is still pending");

endmodule

>>> sv/pss_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on pss_pkg (divider widths). Dividend must be below divisor * 2**DIV_Q_W.
module pss_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pss_pkg::DIV_N_W-1:0]   i_dividend,
    input  logic [pss_pkg::DIV_D_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [pss_pkg::DIV_Q_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(pss_pkg::DIV_Q_W + 1);

    logic [pss_pkg::DIV_D_W-1:0] r_rem, n_rem;
    logic [pss_pkg::DIV_D_W-1:0] r_div;
    logic [pss_pkg::DIV_Q_W-1:0] r_sh, n_sh;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [pss_pkg::DIV_D_W:0]   trial;
    logic [pss_pkg::DIV_D_W:0]   diff;
    logic                        ge;

    // One trial subtract per cycle
    always_comb begin
        trial = {r_rem, r_sh[pss_pkg::DIV_Q_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[pss_pkg::DIV_D_W-1:0] : trial[pss_pkg::DIV_D_W-1:0];
        n_sh  = {r_sh[pss_pkg::DIV_Q_W-2:0], ge};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(pss_pkg::DIV_Q_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CNT_W'(1));
            r_busy <= (r_cnt != CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // Remainder and dividend/quotient shifter
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[pss_pkg::DIV_N_W-1:pss_pkg::DIV_Q_W];
            r_sh  <= i_dividend[pss_pkg::DIV_Q_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_sh  <= n_sh;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh;

endmodule

>>> sv/pss_dp.sv
// Datapath of the point stream subdivider: point registers, distance check,
// step multiply, shared serial divider and the output word register.
// Depends on pss_pkg and pss_div.
module pss_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pss_pkg::t_in_word             i_in_word,
    input  logic [pss_pkg::LIMIT_W-1:0]   i_step_limit,
    input  pss_pkg::t_cmd                 i_cmd,
    output pss_pkg::t_status              o_status,
    output pss_pkg::t_out_word            o_out_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall
);

    localparam int CW = pss_pkg::COORD_W;
    localparam int NW = 2 * CW + 2;

    // Target and current (previous emitted) point
    logic signed [CW-1:0] r_tx, r_ty, r_px, r_py;
    logic                 r_beam, r_fs, r_prev_valid;

    logic [pss_pkg::LIMIT_W-1:0] r_mx, r_k;
    logic signed [NW-1:0]        r_numx, r_numy;
    logic signed [CW-1:0]        r_qx, r_qy;

    pss_pkg::t_out_word r_out_word;
    logic               r_out_valid;

    logic [pss_pkg::LIMIT_W-1:0] lim;
    logic signed [CW:0]          dx, dy;
    logic [CW:0]                 adx_w, ady_w;
    logic [CW-1:0]               adx, ady;
    logic signed [2*CW:0]        prod_x, prod_y;
    logic signed [NW-1:0]        n_numx, n_numy;
    logic [NW-1:0]               magx_w, magy_w;
    logic [pss_pkg::DIV_N_W-1:0] ceil_num;
    logic [pss_pkg::DIV_N_W-1:0] div_num;
    logic [pss_pkg::DIV_D_W-1:0] div_den;
    logic                        div_done;
    logic [pss_pkg::DIV_Q_W-1:0] quot;
    logic [pss_pkg::DIV_Q_W-1:0] quot_neg;
    logic                        out_free;

    // A zero limit acts as one
    assign lim = (i_step_limit == '0) ? pss_pkg::LIMIT_W'(1) : i_step_limit;

    // Per-axis distance from current point to target
    always_comb begin
        dx    = {r_tx[CW-1], r_tx} - {r_px[CW-1], r_px};
        dy    = {r_ty[CW-1], r_ty} - {r_py[CW-1], r_py};
        adx_w = dx[CW] ? (~dx + 1'b1) : dx;
        ady_w = dy[CW] ? (~dy + 1'b1) : dy;
        adx   = adx_w[CW-1:0];
        ady   = ady_w[CW-1:0];
    end

    // Numerator prev*k + (target - prev), one multiply per axis
    always_comb begin
        prod_x = r_px * $signed({1'b0, r_k});
        prod_y = r_py * $signed({1'b0, r_k});
        n_numx = {prod_x[2*CW], prod_x} + {{(NW-CW-1){dx[CW]}}, dx};
        n_numy = {prod_y[2*CW], prod_y} + {{(NW-CW-1){dy[CW]}}, dy};
        magx_w = r_numx[NW-1] ? (~r_numx + 1'b1) : r_numx;
        magy_w = r_numy[NW-1] ? (~r_numy + 1'b1) : r_numy;
    end

    // Divider operand select
    always_comb begin
        ceil_num = pss_pkg::DIV_N_W'(r_mx) + pss_pkg::DIV_N_W'(lim)
                   - pss_pkg::DIV_N_W'(1);
        case (i_cmd.div_sel)
            pss_pkg::DIV_X: begin
                div_num = magx_w[pss_pkg::DIV_N_W-1:0];
                div_den = r_k;
            end
            pss_pkg::DIV_Y: begin
                div_num = magy_w[pss_pkg::DIV_N_W-1:0];
                div_den = r_k;
            end
            default: begin
                div_num = ceil_num;
                div_den = lim;
            end
        endcase
    end

    pss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign quot_neg = ~quot + 1'b1;

    // Point and arithmetic registers; reset clears the current point
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tx   <= i_in_word.pos_x;
            r_ty   <= i_in_word.pos_y;
            r_beam <= i_in_word.beam_on;
            r_fs   <= i_in_word.frame_start;
        end
        if (i_cmd.cap_mx) begin
            r_mx <= (adx > ady) ? adx : ady;
        end
        if (i_cmd.cap_k) begin
            r_k <= quot[pss_pkg::LIMIT_W-1:0];
        end
        if (i_cmd.mul) begin
            r_numx <= n_numx;
            r_numy <= n_numy;
        end
        if (i_cmd.cap_qx) begin
            r_qx <= r_numx[NW-1] ? quot_neg[CW-1:0] : quot[CW-1:0];
        end
        if (i_cmd.cap_qy) begin
            r_qy <= r_numy[NW-1] ? quot_neg[CW-1:0] : quot[CW-1:0];
        end
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
        end else if (i_cmd.emit_mid) begin
            r_px <= r_qx;
            r_py <= r_qy;
        end else if (i_cmd.emit_last) begin
            r_px <= r_tx;
            r_py <= r_ty;
        end
    end

    // Previous point validity; reset clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
        end else if (i_cmd.emit_last) begin
            r_prev_valid <= 1'b1;
        end
    end

    // Output word register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_mid) begin
            r_out_word <= '{out_x: r_qx, out_y: r_qy, out_beam: r_beam, last: 1'b0};
        end else if (i_cmd.emit_last) begin
            r_out_word <= '{out_x: r_tx, out_y: r_ty, out_beam: r_beam, last: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_mid || i_cmd.emit_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.pass     = r_fs || !r_prev_valid;
    assign o_status.far      = (adx > lim) || (ady > lim);
    assign o_status.div_done = div_done;
    assign o_status.out_free = out_free;

    assign o_out_word  = r_out_word;
    assign o_out_valid = r_out_valid;

endmodule

>>> sv/pss_ctrl.sv
// Controller of the point stream subdivider: sequences the distance check,
// the three divisions and the word emits for each input point.
// Depends on pss_pkg (state enum, command and status structs).
module pss_ctrl #(
    parameter int MAX_EMIT = pss_pkg::MAX_EMIT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  pss_pkg::t_status i_status,
    output pss_pkg::t_cmd    o_cmd
);

    localparam int CNT_W = (MAX_EMIT > 2) ? $clog2(MAX_EMIT) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_EMIT - 1);

    pss_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // State and intermediate-word counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pss_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_in_stall    = 1'b1;
        o_cmd         = '0;
        o_cmd.div_sel = pss_pkg::DIV_CEIL;
        unique case (r_state)
            pss_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = pss_pkg::ST_CHECK;
                end
            end
            pss_pkg::ST_CHECK: begin
                if (i_status.pass || !i_status.far || r_cnt == LAST_CNT) begin
                    n_state = pss_pkg::ST_EMIT_LAST;
                end else begin
                    o_cmd.cap_mx = 1'b1;
                    n_state      = pss_pkg::ST_CEIL_GO;
                end
            end
            pss_pkg::ST_CEIL_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = pss_pkg::ST_CEIL_RUN;
            end
            pss_pkg::ST_CEIL_RUN: begin
                if (i_status.div_done) begin
                    o_cmd.cap_k = 1'b1;
                    n_state     = pss_pkg::ST_MUL;
                end
            end
            pss_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = pss_pkg::ST_DIVX_GO;
            end
            pss_pkg::ST_DIVX_GO: begin
                o_cmd.div_sel   = pss_pkg::DIV_X;
                o_cmd.div_start = 1'b1;
                n_state         = pss_pkg::ST_DIVX_RUN;
            end
            pss_pkg::ST_DIVX_RUN: begin
                o_cmd.div_sel = pss_pkg::DIV_X;
                if (i_status.div_done) begin
                    o_cmd.cap_qx = 1'b1;
                    n_state      = pss_pkg::ST_DIVY_GO;
                end
            end
            pss_pkg::ST_DIVY_GO: begin
                o_cmd.div_sel   = pss_pkg::DIV_Y;
                o_cmd.div_start = 1'b1;
                n_state         = pss_pkg::ST_DIVY_RUN;
            end
            pss_pkg::ST_DIVY_RUN: begin
                o_cmd.div_sel = pss_pkg::DIV_Y;
                if (i_status.div_done) begin
                    o_cmd.cap_qy = 1'b1;
                    n_state      = pss_pkg::ST_EMIT_MID;
                end
            end
            pss_pkg::ST_EMIT_MID: begin
                if (i_status.out_free) begin
                    o_cmd.emit_mid = 1'b1;
                    n_cnt          = r_cnt + 1'b1;
                    n_state        = pss_pkg::ST_CHECK;
                end
            end
            pss_pkg::ST_EMIT_LAST: begin
                if (i_status.out_free) begin
                    o_cmd.emit_last = 1'b1;
                    n_state         = pss_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> verif/point_stream_subdivider_tb.sv
// Self-checking testbench for point_stream_subdivider: random and directed point streams,
// an in-bench subdivision predictor, and APB writes/readbacks of step_limit.
// Depends on pss_pkg and the point_stream_subdivider RTL.
module point_stream_subdivider_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EMIT_CAP = pss_pkg::MAX_EMIT_DEF;
    localparam int SETTLE   = 8;     // cycles after the last word before touching the register
    localparam int TAIL     = 100;   // cycles after the last word at the end of the run
    localparam logic [pss_pkg::ADDR_W-1:0] LIMIT_ADDR    = {pss_pkg::REG_STEP_LIMIT, 2'b00};
    localparam logic [pss_pkg::ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    pss_pkg::t_in_word           i_in_word  = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    pss_pkg::t_out_word          o_out_word;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [pss_pkg::ADDR_W-1:0]  paddr   = '0;
    logic [pss_pkg::DATA_W-1:0]  pwdata  = '0;
    logic [pss_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    // Predictor state: register copy and last emitted point
    logic [pss_pkg::LIMIT_W-1:0] cur_limit = pss_pkg::STEP_LIMIT_RST;
    int                          prev_x  = 0;
    int                          prev_y  = 0;
    bit                          prev_ok = 1'b0;

    pss_pkg::t_in_word           target_feed[$];   // targets waiting to be sent
    pss_pkg::t_out_word          due_points[$];    // points the block still owes
    pss_pkg::t_out_word          want;
    int                          gen_x = 0;        // last queued target, for near moves
    int                          gen_y = 0;
    bit                          in_fired = 1'b0;
    bit                          quiet = 1'b0;
    int                          gap_left = 0;
    int                          stall_left = 0;
    int unsigned                 mismatches = 0;

    point_stream_subdivider dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 i_clk = ~i_clk;

    // Expected points for one target: intermediates toward it, then the target marked last
    function automatic void subdivide_target(pss_pkg::t_in_word w);
        int tx, ty, px, py, lim, xd, yd, mx, n;
        longint k;
        pss_pkg::t_out_word pt;
        tx = w.pos_x;
        ty = w.pos_y;
        lim = (cur_limit == 0) ? 1 : int'(cur_limit);
        n = 0;
        if (prev_ok && !w.frame_start) begin
            px = prev_x;
            py = prev_y;
            while (n < EMIT_CAP - 1) begin
                xd = (tx > px) ? tx - px : px - tx;
                yd = (ty > py) ? ty - py : py - ty;
                if (xd <= lim && yd <= lim) break;
                mx = (xd > yd) ? xd : yd;
                k = (longint'(mx) + lim - 1) / lim;
                // exact rational step, truncated toward zero
                px = int'((longint'(px) * k + (tx - px)) / k);
                py = int'((longint'(py) * k + (ty - py)) / k);
                pt.out_x    = 16'(px);
                pt.out_y    = 16'(py);
                pt.out_beam = w.beam_on;
                pt.last     = 1'b0;
                due_points.insert(due_points.size(), pt);
                n++;
            end
        end
        pt.out_x    = w.pos_x;
        pt.out_y    = w.pos_y;
        pt.out_beam = w.beam_on;
        pt.last     = 1'b1;
        due_points.insert(due_points.size(), pt);
        prev_x  = tx;
        prev_y  = ty;
        prev_ok = 1'b1;
    endfunction

    // Input driver: holds a stalled word, otherwise idles in bursts or sends the next one
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fired) begin
            // word not yet taken, keep it
        end else if (gap_left > 0) begin
            i_in_valid <= 1'b0;
            gap_left--;
        end else if (target_feed.size() > 0) begin
            if (!quiet && $urandom_range(0, 4) == 0) begin
                i_in_valid <= 1'b0;
                gap_left = $urandom_range(0, 3);
            end else begin
                i_in_word  <= target_feed.pop_front();
                i_in_valid <= 1'b1;
            end
            in_fired = 1'b0;
        end else begin
            i_in_valid <= 1'b0;
            in_fired = 1'b0;
        end
    end

    // Output stall in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: predict on each accepted target, check each accepted point
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                subdivide_target(i_in_word);
                in_fired = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (due_points.size() == 0) begin
                    $error("unexpected word: out_x=%0d out_y=%0d", o_out_word.out_x,
                           o_out_word.out_y);
                    mismatches++;
                end else begin
                    want = due_points.pop_front();
                    if (o_out_word.out_x !== want.out_x) begin
                        $error("out_x: expected %0d, got %0d", want.out_x, o_out_word.out_x);
                        mismatches++;
                    end
                    if (o_out_word.out_y !== want.out_y) begin
                        $error("out_y: expected %0d, got %0d", want.out_y, o_out_word.out_y);
                        mismatches++;
                    end
                    if (o_out_word.out_beam !== want.out_beam) begin
                        $error("out_beam: expected %0b, got %0b", want.out_beam,
                               o_out_word.out_beam);
                        mismatches++;
                    end
                    if (o_out_word.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_out_word.last);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic apb_write(logic [pss_pkg::ADDR_W-1:0] a, logic [pss_pkg::DATA_W-1:0] d);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (a[pss_pkg::ADDR_W-1:2] == pss_pkg::REG_STEP_LIMIT) begin
            cur_limit = d[pss_pkg::LIMIT_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(logic [pss_pkg::ADDR_W-1:0] a,
                                  logic [pss_pkg::LIMIT_W-1:0] exp_val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[pss_pkg::LIMIT_W-1:0] !== exp_val) begin
            $error("step_limit: expected %0d, got %0d", exp_val,
                   prdata[pss_pkg::LIMIT_W-1:0]);
            mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every target is taken and every point has come out
    task automatic drain();
        while (target_feed.size() != 0 || i_in_valid || due_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic queue_point(int x, int y, bit beam, bit fs);
        pss_pkg::t_in_word w;
        w.pos_x       = 16'(x);
        w.pos_y       = 16'(y);
        w.beam_on     = beam;
        w.frame_start = fs;
        target_feed.insert(target_feed.size(), w);
        gen_x = x;
        gen_y = y;
    endtask

    function automatic int clamp16(int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    // Mostly moves of a few step lengths; some full-range jumps and frame starts
    task automatic queue_random(int count);
        int r, span, lim;
        for (int i = 0; i < count; i++) begin
            lim  = (cur_limit == 0) ? 1 : int'(cur_limit);
            span = 3 * lim;
            r    = $urandom_range(0, 99);
            if (r < 8) begin
                queue_point($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                            $urandom_range(0, 1), $urandom_range(0, 1));
            end else begin
                queue_point(clamp16(gen_x + $urandom_range(0, 2 * span) - span),
                            clamp16(gen_y + $urandom_range(0, 2 * span) - span),
                            $urandom_range(0, 1), r < 14);
            end
        end
    endtask

    task automatic set_limit(int lim);
        drain();
        apb_write(LIMIT_ADDR, {16'($urandom), 16'(lim)});
        apb_read_check(LIMIT_ADDR, 16'(lim));
    endtask

    // Main sequence
    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        apb_read_check(LIMIT_ADDR, pss_pkg::STEP_LIMIT_RST);

        // Reset limit: pass-through with no previous point, corners, frame start, limit edges
        queue_point(32767, -32768, 1, 0);
        queue_point(-32768, 32767, 0, 0);
        queue_point(32767, 32767, 1, 1);
        queue_point(32767, 32767, 0, 0);
        queue_point(32767 - 1152, 32767, 1, 0);
        queue_point(32767 - 1152 - 1153, 32762, 0, 0);
        queue_point(0, -2000, 1, 0);
        queue_point(-1, 1, 1, 0);

        // Zero limit acts as one; a long move hits the emission bound
        set_limit(0);
        queue_point(-32768, -32768, 1, 0);
        queue_point(-32767, -32768, 0, 0);
        queue_point(-32765, -32768, 1, 0);
        queue_point(32767, 32767, 1, 1);
        queue_random(40);

        // Write outside the register map is dropped
        drain();
        apb_write(UNMAPPED_ADDR, 32'h0000_1234);
        apb_read_check(LIMIT_ADDR, 16'd0);

        // Limit below the usual range
        set_limit(1000);
        queue_random(60);

        // Widest limit: even corner to corner needs no step
        set_limit(65535);
        queue_point(32767, 32767, 0, 0);
        queue_point(-32768, -32768, 1, 0);
        queue_point(32767, -32768, 0, 0);
        queue_random(60);

        set_limit(1024);
        queue_random(100);

        set_limit($urandom_range(1024, 65535));
        queue_random(100);

        // Last part without idling on either side
        set_limit(1152);
        quiet = 1'b1;
        queue_random(140);

        drain();
        repeat (TAIL) @(posedge i_clk);
        if (mismatches == 0 && due_points.size() == 0) begin
            $display("point_stream_subdivider: match");
        end else begin
            $display("point_stream_subdivider: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #100_000_000;
        $display("point_stream_subdivider: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
sv/pss_pkg.sv
sv/pss_div.sv
sv/pss_dp.sv
sv/pss_ctrl.sv
sv/point_stream_subdivider.sv
verif/point_stream_subdivider_tb.sv
